// ===== design/lcv_pkg.sv =====
// Shared types and constants of the line clip to viewport core.
package lcv_pkg;

    localparam int CW   = 16;
    localparam int NREG = 8;
    localparam int IW   = 3;

    localparam logic [IW-1:0] R_WL = 3'd0;
    localparam logic [IW-1:0] R_WR = 3'd1;
    localparam logic [IW-1:0] R_WB = 3'd2;
    localparam logic [IW-1:0] R_WT = 3'd3;
    localparam logic [IW-1:0] R_VL = 3'd4;
    localparam logic [IW-1:0] R_VB = 3'd5;
    localparam logic [IW-1:0] R_VR = 3'd6;
    localparam logic [IW-1:0] R_VT = 3'd7;

    localparam logic signed [CW-1:0] RST_WL = 16'sd50;
    localparam logic signed [CW-1:0] RST_WR = 16'sd100;
    localparam logic signed [CW-1:0] RST_WB = 16'sd50;
    localparam logic signed [CW-1:0] RST_WT = 16'sd100;
    localparam logic signed [CW-1:0] RST_VL = 16'sd200;
    localparam logic signed [CW-1:0] RST_VB = 16'sd200;
    localparam logic signed [CW-1:0] RST_VR = 16'sd300;
    localparam logic signed [CW-1:0] RST_VT = 16'sd300;

    typedef struct packed {
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
    } t_seg;

    typedef struct packed {
        logic                 visible;
        logic signed [CW-1:0] view_start_x;
        logic signed [CW-1:0] view_start_y;
        logic signed [CW-1:0] view_end_x;
        logic signed [CW-1:0] view_end_y;
    } t_res;

endpackage

// ===== design/line_clip_to_viewport_core.sv =====
// Top level: Liang-Barsky segment clip against a window, mapped into a viewport.
//
// One segment is taken on every clock at which start is high; busy never rises, so
// segments may follow each other back to back. The result (visible flag and four
// viewport coordinates, zero when invisible) is shown on o_res for exactly one cycle
// with o_done high. The receiver cannot stall; every result must be taken as it appears.
// The pipeline holds two T_FRAC_BITS+1 stage restoring dividers (edge parameter and
// window-relative position) plus thirteen stages of setup, multiply and rounding.
// Configuration writes apply at once and must be made while no segment is in flight.
module line_clip_to_viewport_core #(
    parameter int T_FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  lcv_pkg::t_seg                  i_seg,
    output logic                           o_done,
    output lcv_pkg::t_res                  o_res,
    input  logic                           i_cfg_we,
    input  logic [lcv_pkg::IW-1:0]         i_cfg_idx,
    input  logic [lcv_pkg::CW-1:0]         i_cfg_data
);

    localparam int CW  = lcv_pkg::CW;
    localparam int T   = T_FRAC_BITS;
    localparam int DW  = CW + 1;
    localparam int QB  = T + 1;
    localparam int NW  = DW + QB;
    localparam int EW  = T + 2;
    localparam int PRW = EW + DW;
    localparam int OW  = DW + T + 3;
    localparam int LW  = CW + T;
    localparam int MNW = CW + QB;
    localparam int PW  = QB + CW;
    localparam int VW  = CW + 2;

    localparam logic signed [EW-1:0] T_ONE = EW'(2**T);
    localparam logic signed [EW-1:0] T_SAT = EW'(2**T + 1);
    localparam logic signed [VW-1:0] VMAX  = VW'(2**(CW-1) - 1);
    localparam logic signed [VW-1:0] VMIN  = -VMAX - VW'(1);

    typedef struct packed {
        logic                 win;
        logic [3:0]           pz;
        logic [3:0]           qn;
        logic [3:0]           pn;
        logic [3:0]           sat;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic signed [DW-1:0] bx;
        logic signed [DW-1:0] by;
    } t_eside;

    localparam int ESW = $bits(t_eside);

    // configuration
    logic signed [CW-1:0] r_wl, r_wr, r_wb, r_wt, r_vl, r_vb, r_vr, r_vt;
    logic [CW-1:0]        r_szx, r_szy, r_avx, r_avy;
    logic                 r_vnx, r_vny, r_win_ok;
    logic signed [DW-1:0] w_vwx, w_vwy;

    // pipeline
    logic                 r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld, r7_vld;
    logic                 r8_vld, r9_vld, r10_vld, r11_vld, r12_vld;
    lcv_pkg::t_seg        r1_seg;
    logic signed [DW-1:0] r2_q [4];
    logic signed [DW-1:0] r2_p [4];
    logic [DW-1:0]        r3_aq [4];
    logic [DW-1:0]        r3_ap [4];
    t_eside               r3_sd, w4_sd, r4_sd;
    logic [3:0][NW-1:0]   r4_num;
    logic [3:0][DW-1:0]   r4_den;
    logic                 w_ed_vld;
    logic [3:0][QB-1:0]   w_ed_quo;
    t_eside               w_ed_sd;
    logic signed [EW-1:0] r5_t [4];
    t_eside               r5_sd, r6_sd;
    logic signed [EW-1:0] n6_te, n6_tx, r6_te, r6_tx;
    logic                 n6_rej, r6_rej;
    logic signed [PRW-1:0] r7_prod [4];
    logic signed [DW-1:0] r7_bx, r7_by;
    logic                 r7_vis, r8_vis, r9_vis, r10_vis;
    logic signed [OW-1:0] r8_off [4];
    logic [3:0][LW-1:0]   r9_off;
    logic [3:0][MNW-1:0]  r10_num;
    logic [3:0][CW-1:0]   r10_den;
    logic                 w_mp_vld, w_mp_vis;
    logic [3:0][QB-1:0]   w_mp_quo;
    logic [3:0][PW-1:0]   r11_prod;
    logic                 r11_vis, r12_vis;
    logic [3:0][CW-1:0]   r12_d;
    lcv_pkg::t_res        n_res, r_res;
    logic                 r_done;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl <= lcv_pkg::RST_WL;
            r_wr <= lcv_pkg::RST_WR;
            r_wb <= lcv_pkg::RST_WB;
            r_wt <= lcv_pkg::RST_WT;
            r_vl <= lcv_pkg::RST_VL;
            r_vb <= lcv_pkg::RST_VB;
            r_vr <= lcv_pkg::RST_VR;
            r_vt <= lcv_pkg::RST_VT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lcv_pkg::R_WL: r_wl <= $signed(i_cfg_data);
                lcv_pkg::R_WR: r_wr <= $signed(i_cfg_data);
                lcv_pkg::R_WB: r_wb <= $signed(i_cfg_data);
                lcv_pkg::R_WT: r_wt <= $signed(i_cfg_data);
                lcv_pkg::R_VL: r_vl <= $signed(i_cfg_data);
                lcv_pkg::R_VB: r_vb <= $signed(i_cfg_data);
                lcv_pkg::R_VR: r_vr <= $signed(i_cfg_data);
                lcv_pkg::R_VT: r_vt <= $signed(i_cfg_data);
            endcase
        end
    end

    // derived window / viewport terms
    assign w_vwx = DW'(r_vr) - DW'(r_vl);
    assign w_vwy = DW'(r_vt) - DW'(r_vb);

    always_ff @(posedge i_clk) begin
        r_szx    <= r_wr - r_wl;
        r_szy    <= r_wt - r_wb;
        r_win_ok <= (r_wr > r_wl) && (r_wt > r_wb);
        r_vnx    <= w_vwx[DW-1];
        r_vny    <= w_vwy[DW-1];
        r_avx    <= w_vwx[DW-1] ? CW'(-w_vwx) : w_vwx[CW-1:0];
        r_avy    <= w_vwy[DW-1] ? CW'(-w_vwy) : w_vwy[CW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            r4_vld  <= 1'b0;
            r5_vld  <= 1'b0;
            r6_vld  <= 1'b0;
            r7_vld  <= 1'b0;
            r8_vld  <= 1'b0;
            r9_vld  <= 1'b0;
            r10_vld <= 1'b0;
            r11_vld <= 1'b0;
            r12_vld <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r1_vld  <= start;
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
            r4_vld  <= r3_vld;
            r5_vld  <= w_ed_vld;
            r6_vld  <= r5_vld;
            r7_vld  <= r6_vld;
            r8_vld  <= r7_vld;
            r9_vld  <= r8_vld;
            r10_vld <= r9_vld;
            r11_vld <= w_mp_vld;
            r12_vld <= r11_vld;
            r_done  <= r12_vld;
        end
    end

    // edge terms p, q
    always_ff @(posedge i_clk) begin
        r1_seg  <= i_seg;
        r2_q[0] <= DW'(r1_seg.start_x) - DW'(r_wl);
        r2_q[1] <= DW'(r_wr) - DW'(r1_seg.start_x);
        r2_q[2] <= DW'(r1_seg.start_y) - DW'(r_wb);
        r2_q[3] <= DW'(r_wt) - DW'(r1_seg.start_y);
        r2_p[0] <= DW'(r1_seg.start_x) - DW'(r1_seg.end_x);
        r2_p[1] <= DW'(r1_seg.end_x) - DW'(r1_seg.start_x);
        r2_p[2] <= DW'(r1_seg.start_y) - DW'(r1_seg.end_y);
        r2_p[3] <= DW'(r1_seg.end_y) - DW'(r1_seg.start_y);
    end

    always_ff @(posedge i_clk) begin
        for (int e = 0; e < 4; e++) begin
            r3_ap[e]    <= r2_p[e][DW-1] ? DW'(-r2_p[e]) : r2_p[e];
            r3_aq[e]    <= r2_q[e][DW-1] ? DW'(-r2_q[e]) : r2_q[e];
            r3_sd.pz[e] <= (r2_p[e] == '0);
            r3_sd.qn[e] <= r2_q[e][DW-1];
            r3_sd.pn[e] <= r2_p[e][DW-1];
        end
        r3_sd.sat <= '0;
        r3_sd.win <= r_win_ok;
        r3_sd.dx  <= r2_p[1];
        r3_sd.dy  <= r2_p[3];
        r3_sd.bx  <= r2_q[0];
        r3_sd.by  <= r2_q[2];
    end

    // rounded |t| above 1 saturates, so the quotient needs only T+1 bits
    always_comb begin
        logic [NW-1:0] v_num;
        logic [NW-1:0] v_lim;
        w4_sd = r3_sd;
        for (int e = 0; e < 4; e++) begin
            v_num = NW'({r3_aq[e], {T{1'b0}}}) + NW'(r3_ap[e][DW-1:1]);
            v_lim = NW'({r3_ap[e], {T{1'b0}}}) + NW'(r3_ap[e]);
            w4_sd.sat[e] = (v_num >= v_lim);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int e = 0; e < 4; e++) begin
            r4_num[e] <= NW'({r3_aq[e], {T{1'b0}}}) + NW'(r3_ap[e][DW-1:1]);
            r4_den[e] <= r3_ap[e];
        end
        r4_sd <= w4_sd;
    end

    lcv_div #(
        .LANES (4),
        .DW    (DW),
        .QB    (QB),
        .SW    (ESW)
    ) u_edge_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r4_vld),
        .i_num   (r4_num),
        .i_den   (r4_den),
        .i_side  (r4_sd),
        .o_vld   (w_ed_vld),
        .o_quo   (w_ed_quo),
        .o_side  (w_ed_sd)
    );

    always_ff @(posedge i_clk) begin
        logic signed [EW-1:0] v_mag;
        for (int e = 0; e < 4; e++) begin
            v_mag = w_ed_sd.sat[e] ? T_SAT : EW'(w_ed_quo[e]);
            r5_t[e] <= (w_ed_sd.qn[e] ^ w_ed_sd.pn[e]) ? -v_mag : v_mag;
        end
        r5_sd <= w_ed_sd;
    end

    // entering edges raise te, leaving edges lower tx
    always_comb begin
        n6_te  = '0;
        n6_tx  = T_ONE;
        n6_rej = 1'b0;
        for (int e = 0; e < 4; e++) begin
            if (r5_sd.pz[e]) begin
                n6_rej = n6_rej | r5_sd.qn[e];
            end else if (r5_sd.pn[e]) begin
                if (r5_t[e] > n6_te) begin
                    n6_te = r5_t[e];
                end
            end else begin
                if (r5_t[e] < n6_tx) begin
                    n6_tx = r5_t[e];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r6_te  <= n6_te;
        r6_tx  <= n6_tx;
        r6_rej <= n6_rej;
        r6_sd  <= r5_sd;
    end

    always_ff @(posedge i_clk) begin
        r7_vis     <= r6_sd.win && !r6_rej && (r6_te <= r6_tx);
        r7_prod[0] <= PRW'($signed({1'b0, r6_te[T:0]})) * PRW'(r6_sd.dx);
        r7_prod[1] <= PRW'($signed({1'b0, r6_te[T:0]})) * PRW'(r6_sd.dy);
        r7_prod[2] <= PRW'($signed({1'b0, r6_tx[T:0]})) * PRW'(r6_sd.dx);
        r7_prod[3] <= PRW'($signed({1'b0, r6_tx[T:0]})) * PRW'(r6_sd.dy);
        r7_bx      <= r6_sd.bx;
        r7_by      <= r6_sd.by;
    end

    // lanes: start x, start y, end x, end y
    always_ff @(posedge i_clk) begin
        for (int e = 0; e < 4; e++) begin
            r8_off[e] <= (OW'(e[0] ? r7_by : r7_bx) <<< T) + OW'(r7_prod[e]);
        end
        r8_vis <= r7_vis;
    end

    always_ff @(posedge i_clk) begin
        logic [LW-1:0] v_lim;
        for (int e = 0; e < 4; e++) begin
            v_lim = {(e[0] ? r_szy : r_szx), {T{1'b0}}};
            if (r8_off[e] < 0) begin
                r9_off[e] <= '0;
            end else if (r8_off[e] > $signed(OW'(v_lim))) begin
                r9_off[e] <= v_lim;
            end else begin
                r9_off[e] <= r8_off[e][LW-1:0];
            end
        end
        r9_vis <= r8_vis;
    end

    always_ff @(posedge i_clk) begin
        for (int e = 0; e < 4; e++) begin
            r10_num[e] <= MNW'(r9_off[e]) + MNW'((e[0] ? r_szy : r_szx) >> 1);
            r10_den[e] <= e[0] ? r_szy : r_szx;
        end
        r10_vis <= r9_vis;
    end

    lcv_div #(
        .LANES (4),
        .DW    (CW),
        .QB    (QB),
        .SW    (1)
    ) u_map_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r10_vld),
        .i_num   (r10_num),
        .i_den   (r10_den),
        .i_side  (r10_vis),
        .o_vld   (w_mp_vld),
        .o_quo   (w_mp_quo),
        .o_side  (w_mp_vis)
    );

    always_ff @(posedge i_clk) begin
        for (int e = 0; e < 4; e++) begin
            r11_prod[e] <= PW'(w_mp_quo[e]) * PW'(e[0] ? r_avy : r_avx);
        end
        r11_vis <= w_mp_vis;
    end

    always_ff @(posedge i_clk) begin
        logic [PW:0] v_sum;
        for (int e = 0; e < 4; e++) begin
            v_sum    = (PW+1)'(r11_prod[e]) + (PW+1)'(2**(T-1));
            r12_d[e] <= v_sum[T+CW-1:T];
        end
        r12_vis <= r11_vis;
    end

    always_comb begin
        logic signed [VW-1:0] v_val;
        logic signed [VW-1:0] v_sat;
        logic signed [CW-1:0] v_out [4];
        for (int e = 0; e < 4; e++) begin
            if (e[0] ? r_vny : r_vnx) begin
                v_val = VW'(e[0] ? r_vb : r_vl) - VW'(r12_d[e]);
            end else begin
                v_val = VW'(e[0] ? r_vb : r_vl) + VW'(r12_d[e]);
            end
            if (v_val > VMAX) begin
                v_sat = VMAX;
            end else if (v_val < VMIN) begin
                v_sat = VMIN;
            end else begin
                v_sat = v_val;
            end
            v_out[e] = r12_vis ? v_sat[CW-1:0] : '0;
        end
        n_res.visible      = r12_vis;
        n_res.view_start_x = v_out[0];
        n_res.view_start_y = v_out[1];
        n_res.view_end_x   = v_out[2];
        n_res.view_end_y   = v_out[3];
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== design/lcv_div.sv =====
// Pipelined restoring divider, several lanes, one quotient bit per stage.
module lcv_div #(
    parameter int LANES = 4,
    parameter int DW    = 17,
    parameter int QB    = 17,
    parameter int SW    = 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_vld,
    input  logic [LANES-1:0][DW+QB-1:0]    i_num,
    input  logic [LANES-1:0][DW-1:0]       i_den,
    input  logic [SW-1:0]                  i_side,
    output logic                           o_vld,
    output logic [LANES-1:0][QB-1:0]       o_quo,
    output logic [SW-1:0]                  o_side
);

    // numerator must be below den * 2^QB
    logic [QB-1:0]                  r_vld;
    logic [QB-1:0]                  n_vld;
    logic [LANES-1:0][DW-1:0]       r_rem  [QB];
    logic [LANES-1:0][DW-1:0]       n_rem  [QB];
    logic [LANES-1:0][DW-1:0]       w_rem  [QB];
    logic [LANES-1:0][QB-1:0]       r_low  [QB];
    logic [LANES-1:0][QB-1:0]       w_low  [QB];
    logic [LANES-1:0][QB-1:0]       r_quo  [QB];
    logic [LANES-1:0][QB-1:0]       n_quo  [QB];
    logic [LANES-1:0][QB-1:0]       w_quo  [QB];
    logic [LANES-1:0][DW-1:0]       r_den  [QB];
    logic [LANES-1:0][DW-1:0]       w_den  [QB];
    logic [SW-1:0]                  r_side [QB];
    logic [SW-1:0]                  w_side [QB];

    always_comb begin
        n_vld     = {r_vld[QB-2:0], i_vld};
        w_side[0] = i_side;
        for (int l = 0; l < LANES; l++) begin
            w_rem[0][l] = i_num[l][DW+QB-1:QB];
            w_low[0][l] = i_num[l][QB-1:0];
            w_quo[0][l] = '0;
            w_den[0][l] = i_den[l];
        end
        for (int k = 1; k < QB; k++) begin
            w_rem[k]  = r_rem[k-1];
            w_low[k]  = r_low[k-1];
            w_quo[k]  = r_quo[k-1];
            w_den[k]  = r_den[k-1];
            w_side[k] = r_side[k-1];
        end
    end

    always_comb begin
        logic [DW:0] v_try;
        logic [DW:0] v_dif;
        logic        v_ge;
        for (int k = 0; k < QB; k++) begin
            for (int l = 0; l < LANES; l++) begin
                v_try = {w_rem[k][l], w_low[k][l][QB-1]};
                v_dif = v_try - {1'b0, w_den[k][l]};
                v_ge  = (v_try >= {1'b0, w_den[k][l]});
                n_rem[k][l] = v_ge ? v_dif[DW-1:0] : v_try[DW-1:0];
                n_quo[k][l] = {w_quo[k][l][QB-2:0], v_ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QB; k++) begin
            r_rem[k]  <= n_rem[k];
            r_quo[k]  <= n_quo[k];
            r_den[k]  <= w_den[k];
            r_side[k] <= w_side[k];
            for (int l = 0; l < LANES; l++) begin
                r_low[k][l] <= {w_low[k][l][QB-2:0], 1'b0};
            end
        end
    end

    assign o_vld  = r_vld[QB-1];
    assign o_quo  = r_quo[QB-1];
    assign o_side = r_side[QB-1];

endmodule

// ===== tb/line_clip_to_viewport_core_test.sv =====
// Testbench: segment clipping and viewport mapping checked against a behavioral predictor.
module line_clip_to_viewport_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CW       = lcv_pkg::CW;
    localparam int  IW       = lcv_pkg::IW;
    localparam int  TF       = 16;
    localparam int  LAT      = 2 * TF + 14;
    localparam int  WDOG_LIM = 4000;
    localparam int  N_RAND   = 2000;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    lcv_pkg::t_seg   i_seg = '0;
    logic            o_done;
    lcv_pkg::t_res   o_res;
    logic            i_cfg_we = 1'b0;
    logic [IW-1:0]   i_cfg_idx = '0;
    logic [CW-1:0]   i_cfg_data = '0;

    logic signed [CW-1:0] regs [lcv_pkg::NREG];
    lcv_pkg::t_res        expected_q [$];
    int                   errors = 0;
    int                   idle_cycles = 0;

    line_clip_to_viewport_core #(.T_FRAC_BITS(TF)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_seg(i_seg),
        .o_done(o_done), .o_res(o_res), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // parametric t = q/p, rounded half away from zero
    function automatic longint edge_t(longint q, longint p);
        longint aq, ap, mag;
        aq = q < 0 ? -q : q;
        ap = p < 0 ? -p : p;
        mag = ((aq <<< TF) + ap / 2) / ap;
        return ((q < 0) != (p < 0)) ? -mag : mag;
    endfunction

    function automatic bit edge_pass(longint p, longint q, inout longint te, inout longint tx);
        longint t;
        if (p == 0) return q >= 0;
        t = edge_t(q, p);
        if (p < 0) begin
            if (t > tx) return 0;
            if (t > te) te = t;
        end else begin
            if (t < te) return 0;
            if (t < tx) tx = t;
        end
        return 1;
    endfunction

    function automatic logic signed [CW-1:0] map_axis(longint off, longint size,
                                                       longint vlo, longint vhi);
        longint lim, vw, r, av, d, val;
        lim = size <<< TF;
        vw = vhi - vlo;
        if (off < 0) off = 0;
        if (off > lim) off = lim;
        r = (off + size / 2) / size;
        av = vw < 0 ? -vw : vw;
        d = (r * av + (64'sd1 <<< (TF - 1))) >>> TF;
        val = vw < 0 ? vlo - d : vlo + d;
        if (val > 32767) val = 32767;
        if (val < -32768) val = -32768;
        return val[CW-1:0];
    endfunction

    function automatic lcv_pkg::t_res clip_and_map(lcv_pkg::t_seg s);
        lcv_pkg::t_res r;
        longint x0, y0, x1, y1, wl, wr, wb, wt, dx, dy, te, tx, bx, by;
        bit     vis;
        x0 = s.start_x; y0 = s.start_y; x1 = s.end_x; y1 = s.end_y;
        wl = regs[lcv_pkg::R_WL]; wr = regs[lcv_pkg::R_WR];
        wb = regs[lcv_pkg::R_WB]; wt = regs[lcv_pkg::R_WT];
        dx = x1 - x0; dy = y1 - y0;
        te = 0; tx = 64'sd1 <<< TF;
        r = '0;
        vis = 0;
        if (wr > wl && wt > wb)
            vis = edge_pass(-dx, x0 - wl, te, tx) && edge_pass(dx, wr - x0, te, tx) &&
                  edge_pass(-dy, y0 - wb, te, tx) && edge_pass(dy, wt - y0, te, tx);
        if (!vis) return r;
        bx = (x0 - wl) <<< TF;
        by = (y0 - wb) <<< TF;
        r.visible      = 1'b1;
        r.view_start_x = map_axis(bx + te * dx, wr - wl, regs[lcv_pkg::R_VL],
                                  regs[lcv_pkg::R_VR]);
        r.view_start_y = map_axis(by + te * dy, wt - wb, regs[lcv_pkg::R_VB],
                                  regs[lcv_pkg::R_VT]);
        r.view_end_x   = map_axis(bx + tx * dx, wr - wl, regs[lcv_pkg::R_VL],
                                  regs[lcv_pkg::R_VR]);
        r.view_end_y   = map_axis(by + tx * dy, wt - wb, regs[lcv_pkg::R_VB],
                                  regs[lcv_pkg::R_VT]);
        return r;
    endfunction

    task automatic report(string what, logic [CW-1:0] got, logic [CW-1:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        lcv_pkg::t_res e;
        if (i_rst_n && o_done) begin
            if (expected_q.size() == 0) begin
                report("unexpected result", o_res.view_start_x, '0);
            end else begin
                e = expected_q.pop_front();
                if (o_res.visible !== e.visible) report("visible", o_res.visible, e.visible);
                if (o_res.view_start_x !== e.view_start_x)
                    report("view_start_x", o_res.view_start_x, e.view_start_x);
                if (o_res.view_start_y !== e.view_start_y)
                    report("view_start_y", o_res.view_start_y, e.view_start_y);
                if (o_res.view_end_x !== e.view_end_x)
                    report("view_end_x", o_res.view_end_x, e.view_end_x);
                if (o_res.view_end_y !== e.view_end_y)
                    report("view_end_y", o_res.view_end_y, e.view_end_y);
            end
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIM) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_seg(lcv_pkg::t_seg s, bit allow_gap);
        int gap;
        gap = allow_gap ? $urandom_range(0, 4) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_seg <= s;
        @(posedge i_clk iff !busy);
        expected_q.push_back(clip_and_map(s));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_q.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(logic [IW-1:0] idx, logic signed [CW-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        regs[idx] = val;
    endtask

    task automatic set_regs(int wl, int wr, int wb, int wt, int vl, int vb, int vr, int vt);
        drain();
        write_reg(lcv_pkg::R_WL, wl[CW-1:0]); write_reg(lcv_pkg::R_WR, wr[CW-1:0]);
        write_reg(lcv_pkg::R_WB, wb[CW-1:0]); write_reg(lcv_pkg::R_WT, wt[CW-1:0]);
        write_reg(lcv_pkg::R_VL, vl[CW-1:0]); write_reg(lcv_pkg::R_VB, vb[CW-1:0]);
        write_reg(lcv_pkg::R_VR, vr[CW-1:0]); write_reg(lcv_pkg::R_VT, vt[CW-1:0]);
        i_cfg_we <= 1'b0;
    endtask

    function automatic lcv_pkg::t_seg mk(int x0, int y0, int x1, int y1);
        lcv_pkg::t_seg s;
        s.start_x = x0[CW-1:0]; s.start_y = y0[CW-1:0];
        s.end_x = x1[CW-1:0];   s.end_y = y1[CW-1:0];
        return s;
    endfunction

    function automatic int clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    function automatic int near_coord(int lo, int hi);
        longint span;
        span = longint'(hi) - lo;
        if (span < 4) span = 4;
        return clamp16(lo - span + longint'($urandom_range(0, 32'(3 * span))));
    endfunction

    task automatic test_directed();
        send_seg(mk(60, 60, 90, 90), 0);
        send_seg(mk(0, 75, 150, 75), 0);
        send_seg(mk(75, 0, 75, 150), 0);
        send_seg(mk(0, 0, 150, 150), 0);
        send_seg(mk(150, 150, 0, 0), 0);
        send_seg(mk(0, 0, 40, 40), 0);
        send_seg(mk(110, 60, 140, 90), 0);
        send_seg(mk(60, 10, 90, 40), 0);
        send_seg(mk(60, 110, 90, 140), 0);
        send_seg(mk(40, 60, 40, 90), 0);
        send_seg(mk(75, 75, 75, 75), 0);
        send_seg(mk(50, 100, 50, 100), 0);
        send_seg(mk(101, 75, 101, 75), 0);
        send_seg(mk(-32768, -32768, 32767, 32767), 0);
        send_seg(mk(32767, -32768, -32768, 32767), 0);
        send_seg(mk(-32768, 75, 32767, 76), 0);
        send_seg(mk(0, 51, 200, 52), 1);
        send_seg(mk(51, 0, 53, 200), 1);
    endtask

    task automatic test_special_windows();
        set_regs(100, 100, 50, 100, 200, 200, 300, 300);
        send_seg(mk(100, 60, 100, 90), 1);
        set_regs(50, 100, 120, 40, 200, 200, 300, 300);
        send_seg(mk(0, 0, 150, 150), 1);
        set_regs(50, 100, 50, 100, 300, 300, 200, 200);
        send_seg(mk(0, 0, 150, 150), 1);
        send_seg(mk(60, 70, 80, 95), 1);
        set_regs(-32768, 32767, -32768, 32767, -32768, -32768, 32767, 32767);
        send_seg(mk(-32768, 32767, 32767, -32768), 1);
        send_seg(mk(-1, 0, 1, 0), 1);
        set_regs(0, 1, 0, 1, -32768, 32767, 32767, -32768);
        send_seg(mk(-5, -3, 7, 4), 1);
        set_regs(-10, 10, -10, 10, 32000, -32000, 32767, -32768);
        send_seg(mk(-20, -20, 20, 20), 1);
        send_seg(mk(-20, 20, 20, -20), 1);
    endtask

    task automatic test_random();
        int wl, wr, wb, wt, w, h;
        for (int phase = 0; phase < 10; phase++) begin
            w  = (phase % 3 == 0) ? $urandom_range(1, 65535) : $urandom_range(0, 300);
            h  = (phase % 3 == 0) ? $urandom_range(1, 65535) : $urandom_range(0, 300);
            wl = clamp16($signed(16'($urandom)) - (phase % 3 == 0 ? w / 2 : 0));
            wb = clamp16($signed(16'($urandom)) - (phase % 3 == 0 ? h / 2 : 0));
            wr = clamp16(longint'(wl) + w);
            wt = clamp16(longint'(wb) + h);
            if (phase == 9) begin
                wr = wl - 1;
            end
            set_regs(wl, wr, wb, wt, $signed(16'($urandom)), $signed(16'($urandom)),
                     $signed(16'($urandom)), $signed(16'($urandom)));
            for (int k = 0; k < N_RAND / 10; k++) begin
                if ($urandom_range(0, 9) < 7)
                    send_seg(mk(near_coord(wl, wr), near_coord(wb, wt),
                                near_coord(wl, wr), near_coord(wb, wt)), 1);
                else
                    send_seg(mk($signed(16'($urandom)), $signed(16'($urandom)),
                                $signed(16'($urandom)), $signed(16'($urandom))), 1);
            end
        end
    endtask

    initial begin
        regs[lcv_pkg::R_WL] = lcv_pkg::RST_WL; regs[lcv_pkg::R_WR] = lcv_pkg::RST_WR;
        regs[lcv_pkg::R_WB] = lcv_pkg::RST_WB; regs[lcv_pkg::R_WT] = lcv_pkg::RST_WT;
        regs[lcv_pkg::R_VL] = lcv_pkg::RST_VL; regs[lcv_pkg::R_VB] = lcv_pkg::RST_VB;
        regs[lcv_pkg::R_VR] = lcv_pkg::RST_VR; regs[lcv_pkg::R_VT] = lcv_pkg::RST_VT;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_special_windows();
        test_random();
        drain();
        repeat (LAT + 10) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/lcv_pkg.sv
design/lcv_div.sv
design/line_clip_to_viewport_core.sv
tb/line_clip_to_viewport_core_test.sv
